[rtl/cll_pkg.sv]
// Circular list table: shared types and codes.
// Operation kinds, status codes, controller states and the result bundle.
// No dependencies.
package cll_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int LEN_W   = 7;
   localparam int CODE_W  = 3;
   localparam int SWAP_MIN = 3;

   typedef enum logic [CODE_W-1:0] {
      KIND_APPEND = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_SWAP   = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_BAD_POS   = 3'd3,
      STAT_TOO_FEW   = 3'd4,
      STAT_FULL      = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_SHIFT,
      ST_SWAP_RA,
      ST_SWAP_RB,
      ST_SWAP_WA,
      ST_SWAP_WB,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      status_type          status;
      logic [LEN_W-1:0]    length;
      logic [VALUE_W-1:0]  read_value;
   } rsp_type;

endpackage

[rtl/cll_mem.sv]
// Circular list table: entry RAM, one write and one read port.
// Read data registered: it appears the cycle after the read address. Uses cll_pkg for the data width.
module cll_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [AW-1:0]                 waddr,
   input  logic [cll_pkg::VALUE_W-1:0]   wdata,
   input  logic [AW-1:0]                 raddr,
   output logic [cll_pkg::VALUE_W-1:0]   rdata
);
   import cll_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

[rtl/cll_ctrl.sv]
// Circular list table: operation sequencer and entry count.
// Drives cll_mem through search, close-up and swap passes. Uses cll_pkg.
module cll_ctrl #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cll_pkg::CODE_W-1:0]    req_kind,
   input  logic [cll_pkg::VALUE_W-1:0]   req_value,
   input  logic [cll_pkg::POS_W-1:0]     req_position,
   output logic                          mem_we,
   output logic [AW-1:0]                 mem_waddr,
   output logic [cll_pkg::VALUE_W-1:0]   mem_wdata,
   output logic [AW-1:0]                 mem_raddr,
   input  logic [cll_pkg::VALUE_W-1:0]   mem_rdata,
   output logic                          res_valid,
   input  logic                          res_ready,
   output cll_pkg::rsp_type              res
);
   import cll_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      src_ff, src_in;
   logic [CW-1:0]      dst_ff, dst_in;
   logic               vld_ff, vld_in;
   logic [VALUE_W-1:0] tmp_ff, tmp_in;
   status_type         status_ff, status_in;
   logic [VALUE_W-1:0] rdval_ff, rdval_in;

   logic          is_empty, is_full, pos_bad, too_few;
   logic          found, search_end, shift_end;
   logic [CW-1:0] pos_c, swap_a, swap_b;

   always_comb begin
      pos_c      = CW'(pos_ff);
      is_empty   = (count_ff == '0);
      is_full    = (count_ff >= CW'(DEPTH));
      pos_bad    = (CMPW'(pos_ff) >= CMPW'(count_ff));
      too_few    = (count_ff < CW'(SWAP_MIN));
      found      = vld_ff && (mem_rdata == value_ff);
      search_end = (src_ff == count_ff);
      shift_end  = !vld_ff && (src_ff == count_ff);
      swap_a     = (pos_c == '0) ? count_ff - CW'(1) : pos_c - CW'(1);
      swap_b     = (pos_c + CW'(1) == count_ff) ? '0 : pos_c + CW'(1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (kind_ff)
               KIND_DELETE: state_in = is_empty ? ST_RESP : ST_SEARCH;
               KIND_SWAP:   state_in = (is_empty || pos_bad || too_few) ? ST_RESP : ST_SWAP_RA;
               KIND_READ:   state_in = (is_empty || pos_bad) ? ST_RESP : ST_READ_WAIT;
               default:     state_in = ST_RESP;
            endcase
         end
         ST_SEARCH: begin
            if (found) state_in = ST_SHIFT;
            else if (search_end) state_in = ST_RESP;
         end
         ST_SHIFT: begin
            if (shift_end) state_in = ST_RESP;
         end
         ST_SWAP_RA:   state_in = ST_SWAP_RB;
         ST_SWAP_RB:   state_in = ST_SWAP_WA;
         ST_SWAP_WA:   state_in = ST_SWAP_WB;
         ST_SWAP_WB:   state_in = ST_RESP;
         ST_READ_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      kind_in   = kind_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      vld_in    = vld_ff;
      tmp_in    = tmp_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      mem_we    = 1'b0;
      mem_waddr = dst_ff[AW-1:0];
      mem_wdata = mem_rdata;
      mem_raddr = src_ff[AW-1:0];
      req_ready = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = kind_type'(req_kind);
               value_in  = req_value;
               pos_in    = req_position;
               status_in = STAT_OK;
               rdval_in  = '0;
            end
         end
         ST_DISPATCH: begin
            case (kind_ff)
               KIND_APPEND: begin
                  if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[AW-1:0];
                     mem_wdata = value_ff;
                     count_in  = count_ff + CW'(1);
                  end
               end
               KIND_DELETE: begin
                  if (is_empty) status_in = STAT_EMPTY;
                  src_in = '0;
                  vld_in = 1'b0;
               end
               KIND_SWAP: begin
                  if (is_empty) status_in = STAT_EMPTY;
                  else if (pos_bad) status_in = STAT_BAD_POS;
                  else if (too_few) status_in = STAT_TOO_FEW;
                  dst_in = swap_a;
                  src_in = swap_b;
               end
               KIND_CLEAR: begin
                  count_in = '0;
               end
               KIND_READ: begin
                  if (is_empty) status_in = STAT_EMPTY;
                  else if (pos_bad) status_in = STAT_BAD_POS;
                  mem_raddr = pos_c[AW-1:0];
               end
               default: begin
               end
            endcase
         end
         ST_SEARCH: begin
            if (found) begin
               dst_in = src_ff - CW'(1);
               vld_in = 1'b0;
            end else if (search_end) begin
               status_in = STAT_NOT_FOUND;
               vld_in    = 1'b0;
            end else begin
               mem_raddr = src_ff[AW-1:0];
               src_in    = src_ff + CW'(1);
               vld_in    = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (vld_ff) begin
               mem_we = 1'b1;
               dst_in = dst_ff + CW'(1);
            end
            if (src_ff != count_ff) begin
               mem_raddr = src_ff[AW-1:0];
               src_in    = src_ff + CW'(1);
               vld_in    = 1'b1;
            end else begin
               vld_in = 1'b0;
            end
            if (shift_end) count_in = count_ff - CW'(1);
         end
         ST_SWAP_RA: begin
            mem_raddr = dst_ff[AW-1:0];
         end
         ST_SWAP_RB: begin
            tmp_in = mem_rdata;
         end
         ST_SWAP_WA: begin
            mem_we = 1'b1;
         end
         ST_SWAP_WB: begin
            mem_we    = 1'b1;
            mem_waddr = src_ff[AW-1:0];
            mem_wdata = tmp_ff;
         end
         ST_READ_WAIT: begin
            rdval_in = mem_rdata;
         end
         ST_RESP: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   always_comb begin
      res.status     = status_ff;
      res.length     = LEN_W'(count_ff);
      res.read_value = rdval_ff;
   end

endmodule

[rtl/cll_ostage.sv]
// Circular list table: result output register.
// Holds one finished result for the rsp_ stream. Uses cll_pkg::rsp_type.
module cll_ostage (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_valid,
   output logic              res_ready,
   input  cll_pkg::rsp_type  res,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic [7:0]        rsp_tuser
);
   import cll_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      res_ready = !valid_ff || rsp_tready;
      valid_in  = valid_ff;
      data_in   = data_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (res_valid && res_ready) begin
         valid_in = 1'b1;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, data_ff.read_value, data_ff.length};
   assign rsp_tuser  = {5'b0, data_ff.status};

endmodule

[rtl/circular_list_table_core.sv]
// Circular list table: append, delete by value, neighbour swap, clear and read.
// Append, clear and refusals found at dispatch answer from dispatch; read waits for the
// RAM read; swap reads the two neighbours of the position and writes them back crossed;
// delete searches for the value and, if found, shifts the later entries down over it.
// An input is taken in the cycle after the previous result enters the output register.
// Reset clears the length and both handshakes; RAM contents are left as they are.
module circular_list_table_core #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[37:32], zero
   input  logic [7:0]  req_tuser,   // kind[2:0], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // length[6:0], read_value[38:7], zero
   output logic [7:0]  rsp_tuser    // status[2:0], zero
);
   import cll_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [VALUE_W-1:0] mem_wdata, mem_rdata;
   logic               res_valid, res_ready;
   rsp_type            res;

   cll_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser[CODE_W-1:0]),
      .req_value    (req_tdata[VALUE_W-1:0]),
      .req_position (req_tdata[VALUE_W+POS_W-1:VALUE_W]),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   cll_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   cll_ostage u_ostage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/cll_checker.sv]
// Circular list table: port-level checks over time, bound to the top level.
// Uses cll_pkg status codes.
module cll_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [7:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [7:0]  rsp_tuser
);
   import cll_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !reset && req_tvalid && req_tready |=> !req_tready)
      else $error("second input taken while busy");

   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] != STAT_OK) |-> (rsp_tdata[38:7] == '0))
      else $error("read value not zero on failed operation");

endmodule

bind circular_list_table_core cll_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
